// ----- src/pbpl_pkg.sv -----
// shared types and codes for the page buffer pool with lru replacement
// no dependencies
package pbpl_pkg;

	// request operation codes
	localparam logic [2:0] OP_FETCH     = 3'd0;
	localparam logic [2:0] OP_NEW       = 3'd1;
	localparam logic [2:0] OP_UNPIN     = 3'd2;
	localparam logic [2:0] OP_FLUSH     = 3'd3;
	localparam logic [2:0] OP_FLUSH_ALL = 3'd4;
	localparam logic [2:0] OP_DELETE    = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
	localparam logic [2:0] ST_PINNED       = 3'd2;
	localparam logic [2:0] ST_NO_FRAME     = 3'd3;
	localparam logic [2:0] ST_PIN_ZERO     = 3'd4;

	// most write-backs one flush-all request makes
	localparam int MAX_RESULTS = 16;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic flush_step;
	} pbpl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic flush_go;
		logic flush_last;
	} pbpl_stat_t;

endpackage

// ----- src/pbpl_ctrl.sv -----
// controller state machine for the page buffer pool
// depends on pbpl_pkg
module pbpl_ctrl import pbpl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  pbpl_stat_t stat,
	output pbpl_cmd_t  cmd
);

	typedef enum logic [1:0] {IDLE, EXEC, FLUSH} state_t;

	state_t state_q;

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						busy    <= 1'b1;
					end
				end
				EXEC: begin
					if (stat.flush_go) begin
						state_q <= FLUSH;
					end else begin
						state_q <= IDLE;
						busy    <= 1'b0;
					end
				end
				FLUSH: begin
					if (stat.flush_last) begin
						state_q <= IDLE;
						busy    <= 1'b0;
					end
				end
				default: begin
					state_q <= IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	// command decode
	assign cmd.capture    = (state_q == IDLE) && start;
	assign cmd.execute    = (state_q == EXEC);
	assign cmd.flush_step = (state_q == FLUSH);

endmodule

// ----- src/pbpl_datapath.sv -----
// frame state, free queue, lru ranks and result registers
// depends on pbpl_pkg
module pbpl_datapath import pbpl_pkg::*; #(
	parameter int FRAMES       = 16,
	parameter int PAGE_ID_BITS = 32,
	parameter int PIN_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pbpl_cmd_t   cmd,
	output pbpl_stat_t  stat,
	input  logic [2:0]  operation,
	input  logic [31:0] page_id,
	input  logic        mark_dirty,
	output logic        strobe,
	output logic [2:0]  status,
	output logic        hit,
	output logic [3:0]  frame,
	output logic        write_back,
	output logic [31:0] write_page,
	output logic        read_disk,
	output logic        release_page,
	output logic [4:0]  available_frames,
	output logic        last
);

	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW    = $clog2(FRAMES + 1);
	localparam int TAG_W = (PAGE_ID_BITS < 32) ? PAGE_ID_BITS : 32;
	localparam int KW    = $clog2(MAX_RESULTS);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	// frame state
	logic [TAG_W-1:0]    tag_q   [FRAMES];
	logic [FRAMES-1:0]   valid_q, dirty_q, evict_q;
	logic [PIN_BITS-1:0] pin_q   [FRAMES];
	logic [FW-1:0]       rank_q  [FRAMES];
	logic [FW-1:0]       fq_q    [FRAMES];
	logic [FW-1:0]       head_q;
	logic [CW-1:0]       fcnt_q, lcnt_q;

	// captured request
	logic [2:0]       op_q;
	logic [TAG_W-1:0] page_q;
	logic             mark_q, found_q;
	logic [FW-1:0]    hidx_q;
	logic [FRAMES-1:0] fm_q;
	logic [KW-1:0]    k_q;

	// lookup on the request inputs
	logic [TAG_W-1:0] page_in;
	logic             found_c;
	logic [FW-1:0]    hidx_c;
	assign page_in = page_id[TAG_W-1:0];

	always_comb begin
		found_c = 1'b0;
		hidx_c  = '0;
		for (int g = 0; g < FRAMES; g++) begin
			if (!found_c && valid_q[g] && tag_q[g] == page_in) begin
				found_c = 1'b1;
				hidx_c  = FW'(g);
			end
		end
	end

	// oldest evictable frame and next dirty frame for flush-all
	logic          vic_ok, fl_ok;
	logic [FW-1:0] vic_idx, fl_idx;
	always_comb begin
		vic_ok  = 1'b0;
		vic_idx = '0;
		fl_ok   = 1'b0;
		fl_idx  = '0;
		for (int g = 0; g < FRAMES; g++) begin
			if (!vic_ok && evict_q[g] && rank_q[g] == '0) begin
				vic_ok  = 1'b1;
				vic_idx = FW'(g);
			end
			if (!fl_ok && fm_q[g]) begin
				fl_ok  = 1'b1;
				fl_idx = FW'(g);
			end
		end
	end

	// free queue tail
	logic [CW:0]   tail_sum;
	logic [FW-1:0] tail_idx, head_inc;
	always_comb begin
		tail_sum = {1'b0, CW'(head_q)} + {1'b0, fcnt_q};
		if (tail_sum >= (CW+1)'(FRAMES))
			tail_sum = tail_sum - (CW+1)'(FRAMES);
		tail_idx = tail_sum[FW-1:0];
		head_inc = (head_q == FW'(FRAMES - 1)) ? '0 : head_q + 1'b1;
	end

	// next-state computation
	logic [FRAMES-1:0]   valid_n, dirty_n, evict_n, fm_n;
	logic [PIN_BITS-1:0] pin_n  [FRAMES];
	logic [FW-1:0]       rank_n [FRAMES];
	logic [FW-1:0]       head_n;
	logic [CW-1:0]       fcnt_n, lcnt_n;
	logic [KW-1:0]       k_n;
	logic                tag_we, fq_we, rm_en, emit, flast;
	logic [FW-1:0]       tag_wi, rm_idx, tf;
	logic [TAG_W-1:0]    tag_wd;
	logic [2:0]          o_st;
	logic                o_hit, o_wb, o_rd, o_rel, tf_ok;
	logic [FW-1:0]       o_fr;
	logic [TAG_W-1:0]    o_wp;
	logic [FW-1:0]       rm_r;

	assign stat.flush_go   = (op_q == OP_FLUSH_ALL) && (fm_q != '0);
	assign fm_n            = fm_q & ~(FRAMES'(1) << fl_idx);
	assign flast           = (fm_n == '0) || (k_q == KW'(MAX_RESULTS - 1));
	assign stat.flush_last = flast;

	always_comb begin
		valid_n = valid_q;
		dirty_n = dirty_q;
		evict_n = evict_q;
		pin_n   = pin_q;
		rank_n  = rank_q;
		head_n  = head_q;
		fcnt_n  = fcnt_q;
		lcnt_n  = lcnt_q;
		k_n     = k_q;
		tag_we  = 1'b0;
		tag_wi  = hidx_q;
		tag_wd  = page_q;
		fq_we   = 1'b0;
		rm_en   = 1'b0;
		rm_idx  = hidx_q;
		rm_r    = '0;
		tf      = '0;
		tf_ok   = 1'b0;
		emit    = 1'b0;
		o_st    = ST_OK;
		o_hit   = 1'b0;
		o_fr    = '0;
		o_wb    = 1'b0;
		o_wp    = '0;
		o_rd    = 1'b0;
		o_rel   = 1'b0;
		if (cmd.execute) begin
			emit = 1'b1;
			case (op_q)
				OP_FETCH, OP_NEW: begin
					if (op_q == OP_FETCH && found_q) begin
						// hit: pin and leave lru order
						rm_en  = 1'b1;
						if (pin_q[hidx_q] != PIN_MAX)
							pin_n[hidx_q] = pin_q[hidx_q] + 1'b1;
						o_hit  = 1'b1;
						o_fr   = hidx_q;
					end else begin
						// miss: free queue first, then oldest evictable frame
						if (fcnt_q != '0) begin
							tf_ok  = 1'b1;
							tf     = fq_q[head_q];
							head_n = head_inc;
							fcnt_n = fcnt_q - 1'b1;
						end else if (vic_ok) begin
							tf_ok  = 1'b1;
							tf     = vic_idx;
							rm_en  = 1'b1;
							rm_idx = vic_idx;
							if (valid_q[vic_idx] && dirty_q[vic_idx]) begin
								o_wb = 1'b1;
								o_wp = tag_q[vic_idx];
							end
						end
						if (tf_ok) begin
							tag_we      = 1'b1;
							tag_wi      = tf;
							valid_n[tf] = 1'b1;
							dirty_n[tf] = (op_q == OP_NEW);
							pin_n[tf]   = PIN_BITS'(1);
							o_fr        = tf;
							o_rd        = (op_q == OP_FETCH);
						end else begin
							o_st = ST_NO_FRAME;
						end
					end
				end
				OP_UNPIN: begin
					if (!found_q) begin
						o_st = ST_NOT_RESIDENT;
					end else if (pin_q[hidx_q] == '0) begin
						o_st = ST_PIN_ZERO;
						o_fr = hidx_q;
					end else begin
						pin_n[hidx_q] = pin_q[hidx_q] - 1'b1;
						if (mark_q)
							dirty_n[hidx_q] = 1'b1;
						// last unpin makes the frame the newest evictable one
						if (pin_q[hidx_q] == PIN_BITS'(1)) begin
							evict_n[hidx_q] = 1'b1;
							rank_n[hidx_q]  = lcnt_q[FW-1:0];
							lcnt_n          = lcnt_q + 1'b1;
						end
						o_fr = hidx_q;
					end
				end
				OP_FLUSH: begin
					if (!found_q) begin
						o_st = ST_NOT_RESIDENT;
					end else begin
						dirty_n[hidx_q] = 1'b0;
						o_fr = hidx_q;
						o_wb = 1'b1;
						o_wp = page_q;
					end
				end
				OP_FLUSH_ALL: begin
					// with dirty frames the results come from the flush steps
					emit = (fm_q == '0);
				end
				OP_DELETE: begin
					if (found_q) begin
						o_fr = hidx_q;
						if (pin_q[hidx_q] != '0) begin
							o_st = ST_PINNED;
						end else begin
							valid_n[hidx_q] = 1'b0;
							dirty_n[hidx_q] = 1'b0;
							pin_n[hidx_q]   = '0;
							rm_en           = 1'b1;
							if (fcnt_q != CW'(FRAMES)) begin
								fq_we  = 1'b1;
								fcnt_n = fcnt_q + 1'b1;
							end
							o_rel = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			// drop a frame from lru order and close the rank gap
			if (rm_en && evict_q[rm_idx]) begin
				rm_r = rank_q[rm_idx];
				for (int g = 0; g < FRAMES; g++) begin
					if (evict_q[g] && rank_q[g] > rm_r)
						rank_n[g] = rank_q[g] - 1'b1;
				end
				evict_n[rm_idx] = 1'b0;
				rank_n[rm_idx]  = '0;
				lcnt_n          = lcnt_q - 1'b1;
			end
		end else if (cmd.flush_step) begin
			// one dirty frame written back per step
			emit            = 1'b1;
			dirty_n[fl_idx] = 1'b0;
			k_n             = k_q + 1'b1;
			o_fr            = fl_idx;
			o_wb            = 1'b1;
			o_wp            = tag_q[fl_idx];
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			evict_q <= '0;
			head_q  <= '0;
			fcnt_q  <= CW'(FRAMES);
			lcnt_q  <= '0;
			for (int g = 0; g < FRAMES; g++) begin
				pin_q[g]  <= '0;
				rank_q[g] <= '0;
				fq_q[g]   <= FW'(g);
			end
		end else begin
			valid_q <= valid_n;
			dirty_q <= dirty_n;
			evict_q <= evict_n;
			pin_q   <= pin_n;
			rank_q  <= rank_n;
			head_q  <= head_n;
			fcnt_q  <= fcnt_n;
			lcnt_q  <= lcnt_n;
			if (fq_we)
				fq_q[tail_idx] <= hidx_q;
		end
	end

	// page tags
	always_ff @(posedge clk) begin
		if (tag_we)
			tag_q[tag_wi] <= tag_wd;
	end

	// request capture with registered lookup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			page_q  <= page_in;
			mark_q  <= mark_dirty;
			found_q <= found_c;
			hidx_q  <= hidx_c;
		end
	end

	// flush-all work mask and write count
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fm_q <= valid_q & dirty_q;
			k_q  <= '0;
		end else if (cmd.flush_step) begin
			fm_q <= fm_n;
			k_q  <= k_n;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= emit;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status           <= o_st;
			hit              <= o_hit;
			frame            <= 4'(o_fr);
			write_back       <= o_wb;
			write_page       <= 32'(o_wp);
			read_disk        <= o_rd;
			release_page     <= o_rel;
			available_frames <= 5'((CW+1)'(fcnt_n) + (CW+1)'(lcnt_n));
			last             <= cmd.flush_step ? flast : 1'b1;
		end
	end

endmodule

// ----- src/page_buffer_pool_lru.sv -----
// top level of the page buffer pool with lru replacement
// depends on pbpl_pkg, pbpl_ctrl and pbpl_datapath

// A request is taken when start is high and busy is low; the page lookup is
// registered at that edge and the request executes in the next cycle. Flush-all
// then writes back one dirty frame per step, at most 16. Each result is shown
// for one cycle under strobe, in the cycle after the one that made it, and the
// receiver cannot stall; last marks the final result of a request.
module page_buffer_pool_lru import pbpl_pkg::*; #(
	parameter int FRAMES       = 16,
	parameter int PAGE_ID_BITS = 32,
	parameter int PIN_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] page_id,
	input  logic        mark_dirty,
	output logic        strobe,
	output logic [2:0]  status,
	output logic        hit,
	output logic [3:0]  frame,
	output logic        write_back,
	output logic [31:0] write_page,
	output logic        read_disk,
	output logic        release_page,
	output logic [4:0]  available_frames,
	output logic        last
);

	pbpl_cmd_t  cmd;
	pbpl_stat_t stat;

	// controller
	pbpl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath
	pbpl_datapath #(
		.FRAMES       (FRAMES),
		.PAGE_ID_BITS (PAGE_ID_BITS),
		.PIN_BITS     (PIN_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.operation        (operation),
		.page_id          (page_id),
		.mark_dirty       (mark_dirty),
		.strobe           (strobe),
		.status           (status),
		.hit              (hit),
		.frame            (frame),
		.write_back       (write_back),
		.write_page       (write_page),
		.read_disk        (read_disk),
		.release_page     (release_page),
		.available_frames (available_frames),
		.last             (last)
	);

endmodule

// ----- src/pbpl_checker.sv -----
// port-level checks for the page buffer pool, bound to the top level
// depends on pbpl_pkg
module pbpl_checker import pbpl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [2:0] status,
	input logic       hit,
	input logic       write_back,
	input logic       read_disk,
	input logic       last
);

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy missing after accept");

	// nothing follows the final result of a request
	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("result after last");

	// a result that is not final belongs to a running flush-all
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && write_back) else $error("open result while idle");

	// a fetch hit needs no disk traffic
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && hit |-> status == ST_OK && !write_back && !read_disk)
		else $error("hit with disk request");

endmodule

bind page_buffer_pool_lru pbpl_checker u_pbpl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.status     (status),
	.hit        (hit),
	.write_back (write_back),
	.read_disk  (read_disk),
	.last       (last)
);

// ----- test/pbpl_checker.sv -----
// scoreboard for the page buffer pool: predicts results of each accepted request
// depends on pbpl_pkg; watches the request and result ports of the block
module pool_scoreboard import pbpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [31:0] page_id,
	input  logic        mark_dirty,
	input  logic        strobe,
	input  logic [2:0]  status,
	input  logic        hit,
	input  logic [3:0]  frame,
	input  logic        write_back,
	input  logic [31:0] write_page,
	input  logic        read_disk,
	input  logic        release_page,
	input  logic [4:0]  available_frames,
	input  logic        last,
	output int          fail_count,
	output int          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NF = 16;
	localparam logic [15:0] PIN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [3:0]  frame;
		logic        write_back;
		logic [31:0] write_page;
		logic        read_disk;
		logic        release_page;
		logic [4:0]  available_frames;
		logic        last;
	} pool_result_t;

	// shadow copy of the pool
	logic [31:0] tag_q [NF];
	logic        valid_q [NF];
	logic [15:0] pins_q [NF];
	logic        dirty_q [NF];
	logic [3:0]  freeq_q [NF];
	int          free_head_q, free_cnt_q;
	int          rank_q [NF];
	logic        evict_q [NF];

	pool_result_t expected_results [$];

	function automatic int evict_count();
		int n;
		n = 0;
		for (int g = 0; g < NF; g++) if (evict_q[g]) n++;
		return n;
	endfunction

	function automatic void evict_drop(int f);
		int r;
		if (!evict_q[f]) return;
		r = rank_q[f];
		evict_q[f] = 0;
		rank_q[f] = 0;
		for (int g = 0; g < NF; g++) if (evict_q[g] && rank_q[g] > r) rank_q[g]--;
	endfunction

	function automatic void queue_result(logic [2:0] st, logic h, int f, logic wb,
			logic [31:0] wp, logic rd, logic rel, logic lst);
		pool_result_t r;
		r.status = st; r.hit = h; r.frame = f[3:0]; r.write_back = wb;
		r.write_page = wp; r.read_disk = rd; r.release_page = rel;
		r.available_frames = 5'(free_cnt_q + evict_count()); r.last = lst;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// predict the results of one request and update the shadow state
	function automatic void predict_request(logic [2:0] op, logic [31:0] pg, logic mark);
		int f, k;
		logic wb;
		logic [31:0] wp;
		f = -1;
		for (int g = NF - 1; g >= 0; g--) if (valid_q[g] && tag_q[g] == pg) f = g;
		wb = 0; wp = '0;
		if (op == OP_FETCH && f >= 0) begin
			evict_drop(f);
			if (pins_q[f] < PIN_MAX) pins_q[f]++;
			queue_result(ST_OK, 1, f, 0, 0, 0, 0, 1);
		end else if (op == OP_FETCH || op == OP_NEW) begin
			// miss path: free queue first, then the oldest evictable frame
			f = -1;
			if (free_cnt_q > 0) begin
				f = freeq_q[free_head_q];
				free_head_q = (free_head_q + 1) % NF;
				free_cnt_q--;
			end else begin
				for (int g = 0; g < NF; g++)
					if (f < 0 && evict_q[g] && rank_q[g] == 0) f = g;
				if (f >= 0) begin
					evict_drop(f);
					if (valid_q[f] && dirty_q[f]) begin
						wb = 1; wp = tag_q[f];
					end
					valid_q[f] = 0;
				end
			end
			if (f < 0) queue_result(ST_NO_FRAME, 0, 0, 0, 0, 0, 0, 1);
			else begin
				tag_q[f] = pg; valid_q[f] = 1; dirty_q[f] = (op == OP_NEW);
				pins_q[f] = 1;
				queue_result(ST_OK, 0, f, wb, wp, op == OP_FETCH, 0, 1);
			end
		end else if (op == OP_UNPIN) begin
			if (f < 0) queue_result(ST_NOT_RESIDENT, 0, 0, 0, 0, 0, 0, 1);
			else if (pins_q[f] == 0) queue_result(ST_PIN_ZERO, 0, f, 0, 0, 0, 0, 1);
			else begin
				pins_q[f]--;
				if (mark) dirty_q[f] = 1;
				if (pins_q[f] == 0) begin
					evict_drop(f);
					rank_q[f] = evict_count();
					evict_q[f] = 1;
				end
				queue_result(ST_OK, 0, f, 0, 0, 0, 0, 1);
			end
		end else if (op == OP_FLUSH) begin
			if (f < 0) queue_result(ST_NOT_RESIDENT, 0, 0, 0, 0, 0, 0, 1);
			else begin
				dirty_q[f] = 0;
				queue_result(ST_OK, 0, f, 1, pg, 0, 0, 1);
			end
		end else if (op == OP_FLUSH_ALL) begin
			k = 0;
			for (int g = 0; g < NF; g++)
				if (k < MAX_RESULTS && valid_q[g] && dirty_q[g]) begin
					dirty_q[g] = 0;
					queue_result(ST_OK, 0, g, 1, tag_q[g], 0, 0, 0);
					k++;
				end
			if (k == 0) queue_result(ST_OK, 0, 0, 0, 0, 0, 0, 1);
			else expected_results[$].last = 1;
		end else if (op == OP_DELETE) begin
			if (f < 0) queue_result(ST_OK, 0, 0, 0, 0, 0, 0, 1);
			else if (pins_q[f] > 0) queue_result(ST_PINNED, 0, f, 0, 0, 0, 0, 1);
			else begin
				valid_q[f] = 0; dirty_q[f] = 0; pins_q[f] = 0;
				evict_drop(f);
				if (free_cnt_q < NF) begin
					freeq_q[(free_head_q + free_cnt_q) % NF] = f[3:0];
					free_cnt_q++;
				end
				queue_result(ST_OK, 0, f, 0, 0, 0, 1, 1);
			end
		end else begin
			queue_result(ST_OK, 0, 0, 0, 0, 0, 0, 1);
		end
	endfunction

	// reset the shadow state, then track transactions at each rising edge
	always @(posedge clk or negedge arst_n) begin
		pool_result_t got, want;
		if (!arst_n) begin
			for (int g = 0; g < NF; g++) begin
				tag_q[g] = '0; valid_q[g] = 0; pins_q[g] = '0; dirty_q[g] = 0;
				freeq_q[g] = g[3:0]; rank_q[g] = 0; evict_q[g] = 0;
			end
			free_head_q = 0;
			free_cnt_q = NF;
			expected_results.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			// results first: a result never belongs to a request taken at the same edge
			if (strobe) begin
				got = '{status, hit, frame, write_back, write_page, read_disk,
					release_page, available_frames, last};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: %p", got);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (start && !busy) predict_request(operation, page_id, mark_dirty);
			pending_results = expected_results.size();
		end
	end
endmodule

// ----- test/testbench.sv -----
// top of the page buffer pool testbench: clock, reset, requests and verdict
// depends on pbpl_pkg, page_buffer_pool_lru and pool_scoreboard
module testbench;
	import pbpl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  operation = OP_FETCH;
	logic [31:0] page_id = '0;
	logic        mark_dirty = 0;
	logic        busy, strobe, hit, write_back, read_disk, release_page, last;
	logic [2:0]  status;
	logic [3:0]  frame;
	logic [31:0] write_page;
	logic [4:0]  available_frames;
	int          fail_count, pending_results;
	int          idle_cycles = 0;
	logic [31:0] recent_pages [$];

	always #6 clk = ~clk;

	page_buffer_pool_lru u_dut (.*);

	pool_scoreboard u_checker (.*);

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// issue one request and hold it until accepted
	task automatic send_request(logic [2:0] op, logic [31:0] pg, logic mark);
		@(negedge clk);
		start <= 1; operation <= op; page_id <= pg; mark_dirty <= mark;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start <= 0;
		if (recent_pages.size() > 12) recent_pages.delete(0);
		recent_pages.insert(recent_pages.size(), pg);
	endtask

	function automatic logic [31:0] pick_page();
		if (recent_pages.size() > 0 && $urandom_range(0, 3) != 0)
			return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
		if ($urandom_range(0, 1)) return 32'(1000 + $urandom_range(0, 23));
		return $urandom();
	endfunction

	initial begin
		logic [2:0] op;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extreme ids, every operation, misses, saturated pool
		send_request(OP_UNPIN, 32'h0, 1);
		send_request(OP_FLUSH, 32'hFFFF_FFFF, 0);
		send_request(OP_FLUSH_ALL, 0, 0);
		send_request(OP_DELETE, 32'h1234, 0);
		send_request(OP_NEW, 32'hFFFF_FFFF, 0);
		send_request(OP_FETCH, 32'h0, 0);
		send_request(OP_FETCH, 32'h0, 0);
		send_request(OP_DELETE, 32'h0, 0);
		send_request(OP_UNPIN, 32'h0, 1);
		send_request(OP_UNPIN, 32'h0, 0);
		send_request(OP_UNPIN, 32'h0, 0);
		send_request(OP_FLUSH, 32'hFFFF_FFFF, 0);
		for (int i = 0; i < 15; i++) send_request(OP_NEW, 32'(500 + i), 0);
		send_request(OP_FETCH, 32'hAAAA_5555, 0);
		send_request(OP_UNPIN, 32'hFFFF_FFFF, 1);
		send_request(OP_UNPIN, 32'd500, 0);
		send_request(OP_FETCH, 32'h5555_AAAA, 0);
		send_request(OP_FLUSH_ALL, 0, 1);
		send_request(OP_DELETE, 32'd501, 0);
		send_request(3'd6, 32'h7, 1);
		send_request(3'd7, 32'h8, 0);

		// sender waits for every pending result
		wait (pending_results == 0);

		// random: mostly fetch/unpin pairs on a small page set, plus noise
		for (int i = 0; i < 225; i++) begin
			repeat ($urandom_range(0, 11) * ($urandom_range(0, 3) == 0 ? 0 : 1))
				@(negedge clk);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: op = OP_FETCH;
				6, 7:             op = OP_NEW;
				8, 9, 10, 11, 12, 13: op = OP_UNPIN;
				14, 15:           op = OP_FLUSH;
				16:               op = OP_FLUSH_ALL;
				17, 18:           op = OP_DELETE;
				default:          op = 3'($urandom_range(0, 7));
			endcase
			send_request(op, pick_page(), $urandom_range(0, 1));
			if (i == 110) wait (pending_results == 0);
		end

		wait (pending_results == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
